FILE: hw/rtl/scc_pkg.sv
// Shared types and constants for the stick channel conditioner.
package scc_pkg;

   localparam int CH_W        = 4;
   localparam int SAMPLE_W    = 12;
   localparam int MASK_W      = 10;
   localparam int OUT_W       = 12;
   localparam int DEAD_W      = 10;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 24;
   localparam int STICK_COUNT = 4;
   localparam int MASK_EXT_W  = 1 << CH_W;
   localparam int VAL_MAX     = 4095;

   // range / 5 as (range * BAND_RECIP) >> BAND_SHIFT, exact for range below 2^18
   localparam int BAND_SHIFT  = 18;
   localparam int BAND_RECIP  = 52429;

   localparam logic [MASK_W-1:0] INVERT_MASK_RST = 10'd1008;
   localparam logic [MASK_W-1:0] ANALOG_MASK_RST = 10'd15;
   localparam logic [OUT_W-1:0]  OUT_LOW_RST     = 12'd204;
   localparam logic [OUT_W-1:0]  OUT_HIGH_RST    = 12'd1844;
   localparam logic [DEAD_W-1:0] DEAD_HALF_RST   = 10'd70;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INVERT_MASK = 3'd0,
      CSR_ANALOG_MASK = 3'd1,
      CSR_CALIBRATING = 3'd2,
      CSR_OUT_LOW     = 3'd3,
      CSR_OUT_HIGH    = 3'd4,
      CSR_DEAD_HALF   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [MASK_W-1:0] invert_mask;
      logic [MASK_W-1:0] analog_mask;
      logic              calibrating;
      logic [OUT_W-1:0]  out_low;
      logic [OUT_W-1:0]  out_high;
      logic [DEAD_W-1:0] dead_half;
   } cfg_type;

endpackage

FILE: hw/rtl/scc_cfg_regs.sv
// Configuration register file written through the csr port.
module scc_cfg_regs import scc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.invert_mask <= INVERT_MASK_RST;
         cfg_ff.analog_mask <= ANALOG_MASK_RST;
         cfg_ff.calibrating <= 1'b0;
         cfg_ff.out_low     <= OUT_LOW_RST;
         cfg_ff.out_high    <= OUT_HIGH_RST;
         cfg_ff.dead_half   <= DEAD_HALF_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_INVERT_MASK: cfg_ff.invert_mask <= csr_wr_data[MASK_W-1:0];
            CSR_ANALOG_MASK: cfg_ff.analog_mask <= csr_wr_data[MASK_W-1:0];
            CSR_CALIBRATING: cfg_ff.calibrating <= csr_wr_data[0];
            CSR_OUT_LOW:     cfg_ff.out_low     <= csr_wr_data[OUT_W-1:0];
            CSR_OUT_HIGH:    cfg_ff.out_high    <= csr_wr_data[OUT_W-1:0];
            CSR_DEAD_HALF:   cfg_ff.dead_half   <= csr_wr_data[DEAD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/scc_cal_mem.sv
// Per-channel calibration memory holding min and max, with valid bits for reset values.
module scc_cal_mem import scc_pkg::*; #(
   parameter int NUM_CHANNELS = 10,
   parameter int SAMPLE_BITS  = 12,
   localparam int ADDR_W      = $clog2(NUM_CHANNELS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [SAMPLE_BITS-1:0] wr_min,
   input  logic [SAMPLE_BITS-1:0] wr_max,
   output logic [SAMPLE_BITS-1:0] rd_min,
   output logic [SAMPLE_BITS-1:0] rd_max
);

   logic [2*SAMPLE_BITS-1:0] mem [NUM_CHANNELS];
   logic [2*SAMPLE_BITS-1:0] rd_data_ff;
   logic [NUM_CHANNELS-1:0]  valid_ff;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_max, wr_min};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // an entry never written reads as the reset calibration: min zero, max all ones
   assign rd_min = rd_valid_ff ? rd_data_ff[SAMPLE_BITS-1:0] : '0;
   assign rd_max = rd_valid_ff ? rd_data_ff[2*SAMPLE_BITS-1:SAMPLE_BITS] : '1;

endmodule

FILE: hw/rtl/scc_divider.sv
// Iterative unsigned restoring divider, two quotient bits per cycle.
module scc_divider import scc_pkg::*; #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int STEPS = NUM_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic [DEN_W-1:0] rem_ff, rem_in, rem_v;
   logic [NUM_W-1:0] quo_ff, quo_in, quo_v;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   always_comb begin
      rem_v = rem_ff;
      quo_v = quo_ff;
      trial = '0;
      for (int i = 0; i < 2; i++) begin
         trial = {rem_v, quo_v[NUM_W-1]};
         quo_v = {quo_v[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial    = trial - {1'b0, den_ff};
            quo_v[0] = 1'b1;
         end
         rem_v = trial[DEN_W-1:0];
      end
      rem_in = rem_v;
      quo_in = quo_v;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(STEPS - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

FILE: hw/rtl/stick_channel_conditioner_unit.sv
// Stick channel conditioner: raw select, invert, clamp, map, deadband and calibration update.
// Each request goes through the load, mult, prep, div and finish states before rsp_tvalid;
// the divider gives two quotient bits per step; a zero-width range or bad channel skips it.
// One request at a time: the next is taken once the last result is loaded for the response.
// Reset: synchronous; registers return to their reset values and every calibration entry
// reads as min zero / max all ones at once through per-entry valid bits.
module stick_channel_conditioner_unit import scc_pkg::*; #(
   parameter int NUM_CHANNELS = 10,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // channel[3:0], sample[15:4], level, restart_cal
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_channel[3:0], value[15:4], centered,
                                              // is_up, is_down, cal_changed
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int S      = SAMPLE_BITS;
   localparam int ADDR_W = $clog2(NUM_CHANNELS);
   localparam int RAW_W  = (S > OUT_W) ? S : OUT_W;
   localparam int PROD_W = S + OUT_W + 2;
   localparam int NUM_W  = ((S + OUT_W + 1) / 2) * 2;
   localparam int BAND_W = S + 17;
   localparam int FLAG_W = S + 3;
   localparam int MID_W  = OUT_W + 2;
   localparam int VAL_W  = NUM_W + 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_MULT,
      S_PREP,
      S_DIV,
      S_FIN
   } state_type;

   cfg_type cfg;

   state_type               state_ff;
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;

   logic [CH_W-1:0]         req_ch;
   logic                    accept;
   logic [CH_W-1:0]         ch_ff;
   logic [SAMPLE_W-1:0]     sample_ff;
   logic                    level_ff;
   logic                    restart_ff;
   logic                    ch_ok_ff;
   logic                    stick_ff;

   logic [S-1:0]            rd_min, rd_max;
   logic [MASK_EXT_W-1:0]   an_ext, inv_ext;
   logic                    ch_analog, is_inv;
   logic [RAW_W-1:0]        raw, v, mn_r, mx_r;
   logic [S-1:0]            r_s, x_in;
   logic                    grow_lo, grow_hi;
   logic                    wr_en;
   logic [S-1:0]            wr_min, wr_max;
   logic [S-1:0]            x_ff, mn_ff, mx_ff;
   logic                    changed_ff;

   logic signed [S:0]       diff, den_in;
   logic signed [OUT_W:0]   span, span_adj;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [S:0]       den_ff;
   logic [S-1:0]            range_in, range_ff, delta_ff;
   logic [BAND_W-1:0]       band_prod;

   logic signed [FLAG_W-1:0] xs, mns, mxs, hs, ds;
   logic [NUM_W-1:0]        num_mag;
   logic [S-1:0]            den_mag;
   logic                    zero_in, zero_ff, neg_ff;
   logic signed [MID_W-1:0] mid_in, mid_ff;
   logic                    centered_ff, up_ff, down_ff;
   logic                    div_start, div_done;
   logic [NUM_W-1:0]        quo;

   logic signed [NUM_W:0]   qs;
   logic signed [VAL_W-1:0] val, lo_b, hi_b, mid_v, dh_v;
   logic [OUT_W-1:0]        value_out;

   scc_cfg_regs u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   assign req_ch     = req_tdata[3:0];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   scc_cal_mem #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && ({1'b0, req_ch} < (CH_W + 1)'(NUM_CHANNELS))),
      .rd_addr (req_ch[ADDR_W-1:0]),
      .wr_en   (wr_en),
      .wr_addr (ch_ff[ADDR_W-1:0]),
      .wr_min  (wr_min),
      .wr_max  (wr_max),
      .rd_min  (rd_min),
      .rd_max  (rd_max)
   );

   // raw select, invert and clamp on the calibration just read
   always_comb begin
      an_ext    = MASK_EXT_W'(cfg.analog_mask);
      inv_ext   = MASK_EXT_W'(cfg.invert_mask);
      ch_analog = an_ext[ch_ff];
      is_inv    = inv_ext[ch_ff];
      mn_r      = RAW_W'(rd_min);
      mx_r      = RAW_W'(rd_max);
      if (ch_analog) begin
         raw = RAW_W'(S'(sample_ff));
      end else begin
         raw = level_ff ? RAW_W'(cfg.out_low) : RAW_W'(cfg.out_high);
      end
      if (is_inv) begin
         v = (raw > mx_r) ? mx_r : (mx_r - raw);
      end else begin
         v = raw;
      end
      if (mn_r > v) begin
         x_in = rd_min;
      end else if (mx_r < v) begin
         x_in = rd_max;
      end else begin
         x_in = S'(v);
      end
   end

   // calibration write-back; results keep the old min and max
   always_comb begin
      r_s     = S'(raw);
      grow_lo = cfg.calibrating && (rd_min > r_s);
      grow_hi = cfg.calibrating && !grow_lo && (rd_max < r_s);
      wr_en   = (state_ff == S_LOAD) && ch_ok_ff && (restart_ff || grow_lo || grow_hi);
      if (restart_ff) begin
         wr_min = ch_analog ? r_s : S'(cfg.out_low);
         wr_max = ch_analog ? r_s : S'(cfg.out_high);
      end else begin
         wr_min = grow_lo ? r_s : rd_min;
         wr_max = grow_hi ? r_s : rd_max;
      end
   end

   // map product and band width
   always_comb begin
      diff      = signed'({1'b0, x_ff}) - signed'({1'b0, mn_ff});
      den_in    = signed'({1'b0, mx_ff}) - signed'({1'b0, mn_ff});
      span      = signed'({1'b0, cfg.out_high}) - signed'({1'b0, cfg.out_low});
      prod_in   = PROD_W'(diff) * PROD_W'(span);
      range_in  = mx_ff - mn_ff;
      band_prod = BAND_W'(range_ff) * BAND_W'(BAND_RECIP);
   end

   // flags, divider operands and output mid-point
   always_comb begin
      xs       = FLAG_W'(x_ff);
      mns      = FLAG_W'(mn_ff);
      mxs      = FLAG_W'(mx_ff);
      ds       = FLAG_W'(delta_ff);
      hs       = mns + FLAG_W'(range_ff >> 1);
      num_mag  = prod_ff[PROD_W-1] ? NUM_W'(-prod_ff) : NUM_W'(prod_ff);
      den_mag  = den_ff[S] ? S'(-den_ff) : S'(den_ff);
      zero_in  = (den_ff == '0);
      // halve toward zero
      span_adj = span + (OUT_W + 1)'(span[OUT_W]);
      mid_in   = MID_W'(signed'({1'b0, cfg.out_low})) + MID_W'(span_adj >>> 1);
   end

   assign div_start = (state_ff == S_PREP) && !zero_in;

   scc_divider #(
      .NUM_W (NUM_W),
      .DEN_W (S)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_mag),
      .den   (den_mag),
      .done  (div_done),
      .quo   (quo)
   );

   // offset, deadband and saturate
   always_comb begin
      qs    = neg_ff ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
      if (zero_ff) begin
         val = VAL_W'(signed'({1'b0, cfg.out_low}));
      end else begin
         val = VAL_W'(signed'({1'b0, cfg.out_low})) + VAL_W'(qs);
      end
      mid_v = VAL_W'(mid_ff);
      dh_v  = VAL_W'(signed'({1'b0, cfg.dead_half}));
      lo_b  = mid_v - dh_v;
      hi_b  = mid_v + dh_v;
      if (stick_ff && (lo_b < val) && (val < hi_b)) begin
         val = mid_v;
      end
      if (val < 0) begin
         value_out = '0;
      end else if (val > VAL_W'(VAL_MAX)) begin
         value_out = OUT_W'(VAL_MAX);
      end else begin
         value_out = OUT_W'(val);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff      <= req_ch;
         sample_ff  <= req_tdata[15:4];
         level_ff   <= req_tdata[16];
         restart_ff <= req_tdata[17];
         ch_ok_ff   <= ({1'b0, req_ch} < (CH_W + 1)'(NUM_CHANNELS));
         stick_ff   <= (req_ch < CH_W'(STICK_COUNT));
      end
      if (state_ff == S_LOAD) begin
         x_ff       <= x_in;
         mn_ff      <= rd_min;
         mx_ff      <= rd_max;
         changed_ff <= !restart_ff && (grow_lo || grow_hi);
      end
      if (state_ff == S_MULT) begin
         prod_ff  <= prod_in;
         den_ff   <= den_in;
         range_ff <= range_in;
      end
      if (state_ff == S_PREP) begin
         delta_ff <= S'(band_prod >> BAND_SHIFT);
      end
      if (state_ff == S_PREP) begin
         neg_ff  <= prod_ff[PROD_W-1] ^ den_ff[S];
         zero_ff <= zero_in;
         mid_ff  <= mid_in;
      end
      if (state_ff == S_DIV) begin
         centered_ff <= !((xs < hs - ds) || (xs > hs + ds));
         up_ff       <= xs > mxs - ds;
         down_ff     <= xs < mns + ds;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the finish state reloads the result itself
         if (rsp_valid_ff && rsp_tready && (state_ff != S_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               state_ff <= ch_ok_ff ? S_MULT : S_FIN;
            end
            S_MULT: begin
               state_ff <= S_PREP;
            end
            S_PREP: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // band flags settle here; a zero-width range needs no quotient
               if (zero_ff || div_done) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  if (ch_ok_ff) begin
                     rsp_data_ff <= {4'b0000, changed_ff, down_ff, up_ff, centered_ff,
                                     value_out, ch_ff};
                  end else begin
                     rsp_data_ff <= {(RSP_DATA_W - CH_W)'(0), ch_ff};
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: tb/stick_channel_conditioner_unit_tb.sv
// Self-checking testbench for the stick channel conditioner: directed cases plus random phases.
`timescale 1ns / 1ps

module stick_channel_conditioner_unit_tb;
   import scc_pkg::*;

   localparam int NUM_CH      = 10;
   localparam int BAND_DIV    = 5;
   localparam int SETTLE      = 30;
   localparam int CYCLE_LIMIT = 600000;
   localparam int IDLE_PCT    = 37;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct packed {
      logic [CH_W-1:0]  chan;
      logic [OUT_W-1:0] value;
      logic             centered;
      logic             is_up;
      logic             is_down;
      logic             cal_changed;
   } channel_reading_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   // shadow copy of the registers and the calibration table
   cfg_type               shadow_cfg;
   logic [SAMPLE_W-1:0]   shadow_cal_lo [NUM_CH];
   logic [SAMPLE_W-1:0]   shadow_cal_hi [NUM_CH];
   channel_reading_type   pending_readings [$];

   int                    error_count;
   int                    cycle_count;
   bit                    steady_flow;

   stick_channel_conditioner_unit #(
      .NUM_CHANNELS (NUM_CH),
      .SAMPLE_BITS  (SAMPLE_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic reset_shadow();
      shadow_cfg.invert_mask = INVERT_MASK_RST;
      shadow_cfg.analog_mask = ANALOG_MASK_RST;
      shadow_cfg.calibrating = 1'b0;
      shadow_cfg.out_low     = OUT_LOW_RST;
      shadow_cfg.out_high    = OUT_HIGH_RST;
      shadow_cfg.dead_half   = DEAD_HALF_RST;
      for (int c = 0; c < NUM_CH; c++) begin
         shadow_cal_lo[c] = '0;
         shadow_cal_hi[c] = '1;
      end
   endtask

   // Work out the reading for one request and apply its calibration update.
   task automatic predict_conditioning(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                                       input logic lvl, input logic restart);
      channel_reading_type want;
      logic                analog;
      logic                inv;
      logic [SAMPLE_W-1:0] raw;
      logic [SAMPLE_W-1:0] v;
      logic [SAMPLE_W-1:0] mn;
      logic [SAMPLE_W-1:0] mx;
      logic [SAMPLE_W-1:0] span;
      longint              x, val, mid, half, band, mn_l, mx_l, lo_l, hi_l, dh_l;
      want      = '0;
      want.chan = ch;
      if (ch < NUM_CH) begin
         analog = shadow_cfg.analog_mask[ch];
         inv    = shadow_cfg.invert_mask[ch];
         mn     = shadow_cal_lo[ch];
         mx     = shadow_cal_hi[ch];
         raw    = analog ? smp : (lvl ? shadow_cfg.out_low : shadow_cfg.out_high);
         if (inv)
            v = (raw > mx) ? mx : mx - raw;
         else
            v = raw;
         if (mn > v)
            v = mn;
         else if (mx < v)
            v = mx;
         x    = longint'(v);
         mn_l = longint'(mn);
         mx_l = longint'(mx);
         lo_l = longint'(shadow_cfg.out_low);
         hi_l = longint'(shadow_cfg.out_high);
         dh_l = longint'(shadow_cfg.dead_half);
         if (mx == mn)
            val = lo_l;
         else
            val = lo_l + ((x - mn_l) * (hi_l - lo_l)) / (mx_l - mn_l);
         if (ch < STICK_COUNT) begin
            mid = (hi_l - lo_l) / 2 + lo_l;
            if (mid - dh_l < val && val < mid + dh_l)
               val = mid;
         end
         if (val < 0)
            val = 0;
         if (val > VAL_MAX)
            val = VAL_MAX;
         span          = mx - mn;
         band          = longint'(span) / BAND_DIV;
         half          = mn_l + longint'(span) / 2;
         want.value    = val[OUT_W-1:0];
         want.centered = !(x < half - band || x > half + band);
         want.is_up    = x > mx_l - band;
         want.is_down  = x < mn_l + band;
         if (restart) begin
            shadow_cal_lo[ch] = analog ? raw : shadow_cfg.out_low;
            shadow_cal_hi[ch] = analog ? raw : shadow_cfg.out_high;
         end else if (shadow_cfg.calibrating) begin
            if (mn > raw) begin
               shadow_cal_lo[ch] = raw;
               want.cal_changed  = 1'b1;
            end else if (mx < raw) begin
               shadow_cal_hi[ch] = raw;
               want.cal_changed  = 1'b1;
            end
         end
      end
      pending_readings.push_back(want);
   endtask

   // Called at a falling edge; returns at a falling edge.
   task automatic send_request(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                               input logic lvl, input logic restart);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {6'd0, restart, lvl, smp, ch};
      req_tvalid = 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      predict_conditioning(ch, smp, lvl, restart);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_for_readings();
      while (pending_readings.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   // Write only with nothing in flight.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(posedge clock);
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_INVERT_MASK: shadow_cfg.invert_mask = data[MASK_W-1:0];
         CSR_ANALOG_MASK: shadow_cfg.analog_mask = data[MASK_W-1:0];
         CSR_CALIBRATING: shadow_cfg.calibrating = data[0];
         CSR_OUT_LOW:     shadow_cfg.out_low     = data[OUT_W-1:0];
         CSR_OUT_HIGH:    shadow_cfg.out_high    = data[OUT_W-1:0];
         CSR_DEAD_HALF:   shadow_cfg.dead_half   = data[DEAD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all_csrs(input logic [MASK_W-1:0] inv, input logic [MASK_W-1:0] ana,
                                 input logic cal, input logic [OUT_W-1:0] lo,
                                 input logic [OUT_W-1:0] hi, input logic [DEAD_W-1:0] dh);
      wait_for_readings();
      write_csr(CSR_INVERT_MASK, CSR_DATA_W'(inv));
      write_csr(CSR_ANALOG_MASK, CSR_DATA_W'(ana));
      write_csr(CSR_CALIBRATING, CSR_DATA_W'(cal));
      write_csr(CSR_OUT_LOW, lo);
      write_csr(CSR_OUT_HIGH, hi);
      write_csr(CSR_DEAD_HALF, CSR_DATA_W'(dh));
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      channel_reading_type want;
      channel_reading_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[CH_W-1:0], rsp_tdata[15:4], rsp_tdata[16], rsp_tdata[17],
                rsp_tdata[18], rsp_tdata[19]};
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected reading, expected none, actual channel %0d value %0d",
                     $time, got.chan, got.value);
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            check_field("out_channel", want.chan, got.chan);
            check_field("value", want.value, got.value);
            check_field("centered", want.centered, got.centered);
            check_field("is_up", want.is_up, got.is_up);
            check_field("is_down", want.is_down, got.is_down);
            check_field("cal_changed", want.cal_changed, got.cal_changed);
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic test_reset_defaults();
      send_request(4'd0, 12'd0, 1'b0, 1'b0);
      send_request(4'd0, 12'd4095, 1'b1, 1'b0);
      send_request(4'd1, 12'd2048, 1'b0, 1'b0);
      send_request(4'd2, 12'd1000, 1'b0, 1'b0);
      send_request(4'd3, 12'd3000, 1'b0, 1'b0);
      send_request(4'd4, 12'd0, 1'b0, 1'b0);
      send_request(4'd4, 12'd0, 1'b1, 1'b0);
      send_request(4'd9, 12'd4095, 1'b1, 1'b0);
   endtask

   task automatic test_bad_channels();
      send_request(4'd10, 12'd4095, 1'b1, 1'b1);
      send_request(4'd15, 12'd2730, 1'b0, 1'b1);
   endtask

   task automatic test_restart_and_zero_width();
      send_request(4'd1, 12'd100, 1'b0, 1'b1);
      send_request(4'd1, 12'd100, 1'b0, 1'b0);
      send_request(4'd1, 12'd50, 1'b0, 1'b0);
      send_request(4'd5, 12'd0, 1'b0, 1'b1);
      send_request(4'd5, 12'd0, 1'b1, 1'b0);
   endtask

   task automatic test_calibration_widening();
      wait_for_readings();
      write_csr(CSR_CALIBRATING, CSR_DATA_W'(1));
      send_request(4'd2, 12'd2000, 1'b0, 1'b1);
      send_request(4'd2, 12'd1500, 1'b0, 1'b0);
      send_request(4'd2, 12'd2500, 1'b0, 1'b0);
      send_request(4'd2, 12'd2000, 1'b0, 1'b0);
   endtask

   task automatic test_inverted_overflow();
      wait_for_readings();
      write_csr(CSR_INVERT_MASK, CSR_DATA_W'(10'h3FF));
      write_csr(CSR_CALIBRATING, CSR_DATA_W'(0));
      send_request(4'd2, 12'd3000, 1'b0, 1'b0);
      send_request(4'd2, 12'd600, 1'b0, 1'b0);
   endtask

   // out_low above out_high: a digital restart leaves min above max
   task automatic test_crossed_endpoints();
      wait_for_readings();
      write_csr(CSR_OUT_LOW, 12'd4095);
      write_csr(CSR_OUT_HIGH, 12'd0);
      send_request(4'd6, 12'd0, 1'b0, 1'b1);
      send_request(4'd6, 12'd0, 1'b1, 1'b0);
      send_request(4'd6, 12'd0, 1'b0, 1'b0);
   endtask

   task automatic send_random_request();
      logic [CH_W-1:0]     ch;
      logic [SAMPLE_W-1:0] smp;
      ch = ($urandom_range(99) < 90) ? CH_W'($urandom_range(NUM_CH - 1))
                                     : CH_W'($urandom_range(15, NUM_CH));
      if ($urandom_range(9) == 0)
         smp = $urandom_range(1) ? '1 : '0;
      else
         smp = SAMPLE_W'($urandom_range(4095));
      send_request(ch, smp, 1'($urandom_range(1)), $urandom_range(99) < 12);
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_all_csrs('0, '0, 1'b0, 12'd0, 12'd4095, '0);
            1: write_all_csrs('1, '1, 1'b1, 12'd4095, 12'd0, '1);
            2: write_all_csrs(INVERT_MASK_RST, ANALOG_MASK_RST, 1'b1, OUT_LOW_RST,
                              OUT_HIGH_RST, DEAD_HALF_RST);
            default: write_all_csrs(MASK_W'($urandom_range(1023)), MASK_W'($urandom_range(1023)),
                                    1'($urandom_range(1)), OUT_W'($urandom_range(4095)),
                                    OUT_W'($urandom_range(4095)), DEAD_W'($urandom_range(1023)));
         endcase
         if (phase == 3)
            write_csr(CSR_SPARE_A, 12'hFFF);
         if (phase == 4)
            write_csr(CSR_SPARE_B, 12'hABC);
         steady_flow = (phase == 5);
         for (int n = 0; n < 102; n++) begin
            // hold until every reading is back, mid-stream
            if (phase == 3 && n == 50)
               wait_for_readings();
            send_random_request();
         end
         steady_flow = 1'b0;
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wr_data = '0;
      error_count = 0;
      cycle_count = 0;
      steady_flow = 1'b0;
      reset_shadow();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_bad_channels();
      test_restart_and_zero_width();
      test_calibration_widening();
      test_inverted_overflow();
      test_crossed_endpoints();
      test_random_phases();

      wait_for_readings();
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
